/* sv/mpd_pkg.sv */
// shared types, widths and register codes for the minimum pair distance check
// no dependencies; used by mpd_dist_unit and min_pair_distance_check
package mpd_pkg;

  localparam int COORD_BITS      = 16;
  localparam int DIST_BITS       = 34;
  localparam int IDX_BITS        = 10;
  localparam int TOTAL_BITS      = 11;
  localparam int DIM_CFG_BITS    = 3;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 34;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_DIM_DEF     = 4;

  localparam logic [DIM_CFG_BITS-1:0] DIM_RESET = 3'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSION = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DIST  = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] coord_value;
    logic                  last_of_set;
  } coord_item_t;

  typedef struct packed {
    logic                  check_failed;
    logic [IDX_BITS-1:0]   first_index;
    logic [IDX_BITS-1:0]   second_index;
    logic [DIST_BITS-1:0]  closest_dist_sq;
    logic [TOTAL_BITS-1:0] sample_total;
    logic                  overflowed;
  } result_item_t;

  // one coordinate step of a pair going through the distance unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } step_ctl_t;

  // bits of a sum of max_dim squared coordinate differences
  function automatic int acc_bits(input int max_dim);
    return 2 * COORD_BITS + $clog2(max_dim);
  endfunction

  // width that holds both a distance sum and the threshold
  function automatic int cmp_bits(input int max_dim);
    return (acc_bits(max_dim) > DIST_BITS) ? acc_bits(max_dim) : DIST_BITS;
  endfunction

endpackage

/* sv/mpd_dist_unit.sv */
// sample store with a shared difference / square / accumulate pipeline
// depends on mpd_pkg; one coordinate pair enters per cycle, sums leave in order
module mpd_dist_unit #(
  parameter int MAX_SAMPLES = mpd_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_DIM     = mpd_pkg::MAX_DIM_DEF,
  localparam int IW         = $clog2(MAX_SAMPLES),
  localparam int KW         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int AW         = IW + KW,
  localparam int TW         = 2 * IW,
  localparam int ACCW       = mpd_pkg::acc_bits(MAX_DIM),
  localparam int CB         = mpd_pkg::COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [mpd_pkg::COORD_BITS-1:0]   wr_data,
  input  mpd_pkg::step_ctl_t               step,
  input  logic [AW-1:0]                    addr_a,
  input  logic [AW-1:0]                    addr_b,
  input  logic [TW-1:0]                    tag,
  output logic                             sum_valid,
  output logic [ACCW-1:0]                  sum,
  output logic [TW-1:0]                    sum_tag,
  output logic                             busy
);

  logic [CB-1:0] store [2**AW];

  logic [CB-1:0]      rd_a;
  logic [CB-1:0]      rd_b;
  mpd_pkg::step_ctl_t s1_ctl;
  logic [TW-1:0]      s1_tag;

  logic [CB-1:0]      diff;
  logic [2*CB-1:0]    sq;
  mpd_pkg::step_ctl_t s2_ctl;
  logic [TW-1:0]      s2_tag;

  logic [ACCW-1:0]    acc;
  logic [ACCW-1:0]    acc_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_a <= store[addr_a];
    rd_b <= store[addr_b];
  end

  assign diff = (rd_a > rd_b) ? (rd_a - rd_b) : (rd_b - rd_a);
  assign acc_next = (s2_ctl.first ? '0 : acc) + ACCW'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      sum_valid <= 1'b0;
    end else begin
      s1_ctl    <= step;
      s2_ctl    <= s1_ctl;
      sum_valid <= s2_ctl.valid && s2_ctl.last;
    end
    s1_tag  <= tag;
    sq      <= (2*CB)'(diff) * (2*CB)'(diff);
    s2_tag  <= s1_tag;
    sum_tag <= s2_tag;
    sum     <= acc_next;
    if (s2_ctl.valid) begin
      acc <= acc_next;
    end
  end

  assign busy = s1_ctl.valid || s2_ctl.valid || sum_valid;

endmodule

/* sv/min_pair_distance_check.sv */
// Minimum pair distance check. Coordinates stream in one item per cycle while coord_stall
// is low and are stored as samples of dimension_in_use coordinates (latched at the first
// coordinate of a set; 0 acts as 1, values above MAX_DIM as MAX_DIM). The item with
// last_of_set closes the set: a trailing partial sample is dropped, and then every pair
// i < j of the N stored samples is compared by squared distance. The scan feeds one
// coordinate pair per cycle through a single difference / square / accumulate pipeline fed
// by the two read ports of the sample store. coord_stall is high from the last item of a
// set while the set is scanned and drained and until its result can enter the result
// register, which the previous result may still hold. One result item is given per set;
// the next set may load while that result waits on result_stall. The closest pair strictly
// below min_distance_sq fails the check (first such pair wins ties); otherwise the result
// is a pass with both indices zero and the distance equal to the threshold. Samples past
// MAX_SAMPLES are dropped and flagged. The store needs no clearing after reset.
// depends on mpd_pkg and mpd_dist_unit
module min_pair_distance_check #(
  parameter int MAX_SAMPLES = mpd_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_DIM     = mpd_pkg::MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mpd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 coord_valid,
  output logic                                 coord_stall,
  input  mpd_pkg::coord_item_t                 coord,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output mpd_pkg::result_item_t                result
);

  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int KW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int TW   = 2 * IW;
  localparam int ACCW = mpd_pkg::acc_bits(MAX_DIM);
  localparam int CMPW = mpd_pkg::cmp_bits(MAX_DIM);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [mpd_pkg::DIM_CFG_BITS-1:0] cfg_dim;
  logic [mpd_pkg::DIST_BITS-1:0]    cfg_thr;

  logic [CNTW-1:0] cnt;
  logic [KW-1:0]   pos;
  logic            ovf;
  logic [DW-1:0]   set_dim;

  logic [CNTW-1:0] scan_n;
  logic            scan_ovf;
  logic [IW-1:0]   i;
  logic [IW-1:0]   j;
  logic [KW-1:0]   k;

  logic [CMPW-1:0] best;
  logic [IW-1:0]   bi;
  logic [IW-1:0]   bj;
  logic            found;

  logic            accept;
  logic [DW-1:0]   dim_clamped;
  logic [DW-1:0]   dim_use;
  logic [DW-1:0]   pos_inc;
  logic            cnt_full;
  logic            sample_done;
  logic [CNTW-1:0] cnt_next;
  logic            ovf_next;
  logic            k_last;
  logic            j_last;
  logic            i_last;

  mpd_pkg::step_ctl_t step;
  logic               sum_valid;
  logic [ACCW-1:0]    sum;
  logic [TW-1:0]      sum_tag;
  logic               busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dim <= mpd_pkg::DIM_RESET;
      cfg_thr <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mpd_pkg::REG_DIMENSION: cfg_dim <= cfg_data[mpd_pkg::DIM_CFG_BITS-1:0];
        mpd_pkg::REG_MIN_DIST:  cfg_thr <= cfg_data[mpd_pkg::DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign coord_stall = (state != S_LOAD);
  assign accept      = coord_valid && !coord_stall;

  always_comb begin
    if (cfg_dim == '0) begin
      dim_clamped = DW'(1);
    end else if (32'(cfg_dim) > MAX_DIM) begin
      dim_clamped = DW'(MAX_DIM);
    end else begin
      dim_clamped = DW'(cfg_dim);
    end
  end

  // dimension is latched only at the first coordinate of a set
  assign dim_use     = (cnt == '0 && pos == '0 && !ovf) ? dim_clamped : set_dim;
  assign pos_inc     = DW'(pos) + DW'(1);
  assign cnt_full    = (cnt == CNTW'(MAX_SAMPLES));
  assign sample_done = (pos_inc >= dim_use);
  assign cnt_next    = (sample_done && !cnt_full) ? cnt + CNTW'(1) : cnt;
  assign ovf_next    = ovf || (sample_done && cnt_full);

  assign k_last = (k == KW'(set_dim - DW'(1)));
  assign j_last = (CNTW'(j) == scan_n - CNTW'(1));
  assign i_last = (CNTW'(i) == scan_n - CNTW'(2));

  always_comb begin
    step.valid = (state == S_SCAN);
    step.first = (k == '0);
    step.last  = k_last;
  end

  mpd_dist_unit #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_DIM     (MAX_DIM)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && !cnt_full),
    .wr_addr   ({cnt[IW-1:0], pos}),
    .wr_data   (coord.coord_value),
    .step      (step),
    .addr_a    ({i, k}),
    .addr_b    ({j, k}),
    .tag       ({i, j}),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_tag   (sum_tag),
    .busy      (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      cnt          <= '0;
      pos          <= '0;
      ovf          <= 1'b0;
      set_dim      <= DW'(mpd_pkg::DIM_RESET);
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            set_dim <= dim_use;
            if (coord.last_of_set) begin
              cnt    <= '0;
              pos    <= '0;
              ovf    <= 1'b0;
              found  <= 1'b0;
              state  <= (cnt_next < CNTW'(2)) ? S_DONE : S_SCAN;
            end else begin
              cnt <= cnt_next;
              pos <= sample_done ? '0 : KW'(pos_inc);
              ovf <= ovf_next;
            end
          end
        end
        S_SCAN: begin
          if (k_last && j_last && i_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
      // strict compare keeps the earliest pair on ties
      if (sum_valid && CMPW'(sum) < best) begin
        found <= 1'b1;
      end
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    if (state == S_LOAD && accept && coord.last_of_set) begin
      scan_n   <= cnt_next;
      scan_ovf <= ovf_next;
      best     <= CMPW'(cfg_thr);
      bi       <= '0;
      bj       <= '0;
      i        <= '0;
      j        <= IW'(1);
      k        <= '0;
    end else begin
      if (state == S_SCAN) begin
        if (k_last) begin
          k <= '0;
          if (j_last) begin
            i <= i + IW'(1);
            j <= i + IW'(2);
          end else begin
            j <= j + IW'(1);
          end
        end else begin
          k <= k + KW'(1);
        end
      end
      if (sum_valid && CMPW'(sum) < best) begin
        best <= CMPW'(sum);
        bi   <= sum_tag[TW-1:IW];
        bj   <= sum_tag[IW-1:0];
      end
    end
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      result.check_failed    <= found;
      result.first_index     <= mpd_pkg::IDX_BITS'(bi);
      result.second_index    <= mpd_pkg::IDX_BITS'(bj);
      result.closest_dist_sq <= mpd_pkg::DIST_BITS'(best);
      result.sample_total    <= mpd_pkg::TOTAL_BITS'(scan_n);
      result.overflowed      <= scan_ovf;
    end
  end

  a_sum_in_scan: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("distance sum outside of a scan");

  a_found_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && found) |-> (best < CMPW'(cfg_thr)))
    else $error("reported pair not below threshold");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside of done state");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (i < j && CNTW'(j) < scan_n))
    else $error("pair indices out of order or range");

endmodule

/* sim/tb_min_pair_distance_check.sv */
// self-checking testbench for min_pair_distance_check: random gaps and stalls on both channels
// depends on mpd_pkg and the min_pair_distance_check rtl; the scoreboard below predicts results
module tb_min_pair_distance_check;
  import mpd_pkg::*;

  localparam logic [DIST_BITS-1:0] THR_MAX     = 34'd17179344900;
  localparam int                   TOTAL_ITEMS = 1650;

  class closest_pair_scoreboard;
    logic [COORD_BITS-1:0] store [MAX_SAMPLES_DEF*MAX_DIM_DEF];
    int unsigned           count;
    int unsigned           pos;
    int unsigned           set_dim;
    bit                    over;
    logic [DIM_CFG_BITS-1:0] dim_reg;
    longint unsigned       thr_reg;
    result_item_t          pending_results[$];
    int                    errors;

    function new();
      count   = 0;
      pos     = 0;
      over    = 0;
      set_dim = 2;
      dim_reg = DIM_RESET;
      thr_reg = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_DIMENSION) begin
        dim_reg = data[DIM_CFG_BITS-1:0];
      end else if (idx == REG_MIN_DIST) begin
        thr_reg = data;
      end
    endfunction

    function void take_coord(coord_item_t item);
      result_item_t    r;
      longint unsigned best, acc, x, y, d;
      int unsigned     bi, bj, i, j, k;
      // dimension is latched only at the first coordinate of a set
      if (count == 0 && pos == 0 && !over) begin
        if (dim_reg == 0) set_dim = 1;
        else if (dim_reg > MAX_DIM_DEF) set_dim = MAX_DIM_DEF;
        else set_dim = dim_reg;
      end
      if (count < MAX_SAMPLES_DEF && pos < MAX_DIM_DEF)
        store[count*MAX_DIM_DEF + pos] = item.coord_value;
      pos++;
      if (pos >= set_dim) begin
        pos = 0;
        if (count < MAX_SAMPLES_DEF) count++;
        else over = 1;
      end
      if (!item.last_of_set) return;
      best = thr_reg;
      bi = 0;
      bj = 0;
      for (i = 0; i < count; i++) begin
        for (j = i + 1; j < count; j++) begin
          acc = 0;
          for (k = 0; k < set_dim; k++) begin
            x = store[i*MAX_DIM_DEF + k];
            y = store[j*MAX_DIM_DEF + k];
            d = (x > y) ? x - y : y - x;
            acc += d * d;
          end
          if (acc < best) begin
            best = acc;
            bi = i;
            bj = j;
          end
        end
      end
      r.check_failed    = (best < thr_reg);
      r.first_index     = bi[IDX_BITS-1:0];
      r.second_index    = bj[IDX_BITS-1:0];
      r.closest_dist_sq = best[DIST_BITS-1:0];
      r.sample_total    = count[TOTAL_BITS-1:0];
      r.overflowed      = over;
      pending_results = {pending_results, r};
      count = 0;
      pos   = 0;
      over  = 0;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_item_t got);
      result_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("check_failed", want.check_failed, got.check_failed);
      compare_field("first_index", want.first_index, got.first_index);
      compare_field("second_index", want.second_index, got.second_index);
      compare_field("closest_dist_sq", want.closest_dist_sq, got.closest_dist_sq);
      compare_field("sample_total", want.sample_total, got.sample_total);
      compare_field("overflowed", want.overflowed, got.overflowed);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      coord_valid = 1'b0;
  logic                      coord_stall;
  coord_item_t               coord = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_item_t              result;

  closest_pair_scoreboard sb = new();
  bit steady     = 1'b0;
  int dim_eff    = 2;
  int items_sent = 0;

  min_pair_distance_check dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coord_valid  (coord_valid),
    .coord_stall  (coord_stall),
    .coord        (coord),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && coord_valid && !coord_stall) sb.take_coord(coord);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // receiver raises result_stall at random before each result item, never in steady mode
  initial begin : result_stall_gen
    int n;
    forever begin
      n = steady ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  task automatic send_coord(input logic [COORD_BITS-1:0] value, input bit last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      coord_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord_valid       <= 1'b1;
    coord.coord_value <= value;
    coord.last_of_set <= last;
    @(posedge clk);
    while (coord_stall) @(posedge clk);
    items_sent++;
  endtask

  // writes both registers on consecutive cycles while the block is idle
  task automatic set_config(input logic [DIM_CFG_BITS-1:0] dim, input logic [DIST_BITS-1:0] thr);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DIMENSION;
    cfg_data  <= CFG_DATA_BITS'(dim);
    @(posedge clk);
    sb.write_reg(REG_DIMENSION, CFG_DATA_BITS'(dim));
    cfg_index <= REG_MIN_DIST;
    cfg_data  <= thr;
    @(posedge clk);
    sb.write_reg(REG_MIN_DIST, thr);
    cfg_wr_en <= 1'b0;
    if (dim == 0) dim_eff = 1;
    else if (dim > MAX_DIM_DEF) dim_eff = MAX_DIM_DEF;
    else dim_eff = dim;
  endtask

  // drain all results, then let the scan pipeline settle
  task automatic finish_phase();
    coord_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_set(input int n, input int partial, input int span);
    int total;
    int base;
    base  = $urandom_range(0, 65535);
    total = n * dim_eff + partial;
    if (total == 0) total = 1;
    for (int i = 0; i < total; i++)
      send_coord(COORD_BITS'(base + $urandom_range(0, span)), i == total - 1);
  endtask

  initial begin : stimulus
    logic [DIST_BITS-1:0] thr;
    int                   d;
    int                   r;
    int                   span;
    int                   partial;
    int                   n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: two dims, zero threshold never fails
    send_coord(16'h0000, 1'b0);
    send_coord(16'h0000, 1'b0);
    send_coord(16'hFFFF, 1'b0);
    send_coord(16'hFFFF, 1'b1);
    finish_phase();

    // farthest possible pair equals the top threshold, so it passes
    set_config(3'd4, THR_MAX);
    repeat (4) send_coord(16'h0000, 1'b0);
    repeat (3) send_coord(16'hFFFF, 1'b0);
    send_coord(16'hFFFF, 1'b1);
    finish_phase();

    // equal distances: first pair in scan order wins
    set_config(3'd1, 34'd5);
    send_coord(16'd100, 1'b0);
    send_coord(16'd102, 1'b0);
    send_coord(16'd104, 1'b1);
    finish_phase();

    // trailing partial sample dropped
    set_config(3'd3, 34'd5);
    for (int i = 1; i <= 5; i++) send_coord(COORD_BITS'(i), i == 5);
    finish_phase();

    // zero dimension acts as one
    set_config(3'd0, '1);
    send_coord(16'h5A5A, 1'b1);
    finish_phase();

    // dimension above range acts as the maximum
    set_config(3'd7, 34'd1);
    for (int i = 0; i < 8; i++) send_coord(16'h1234, i == 7);
    finish_phase();

    // fill past capacity; closest pair sits at the top two indexes
    set_config(3'd1, THR_MAX);
    for (int i = 0; i < MAX_SAMPLES_DEF + 2; i++) begin
      if (i < MAX_SAMPLES_DEF - 2) send_coord(COORD_BITS'(i * 64), 1'b0);
      else if (i == MAX_SAMPLES_DEF - 2) send_coord(16'd65408, 1'b0);
      else if (i == MAX_SAMPLES_DEF - 1) send_coord(16'd65409, 1'b0);
      else send_coord(COORD_BITS'($urandom), i == MAX_SAMPLES_DEF + 1);
    end
    finish_phase();

    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 8) d = $urandom_range(1, 4);
      else if (r == 8) d = 0;
      else d = $urandom_range(5, 7);
      case ($urandom_range(0, 5))
        0: thr = '0;
        1: thr = THR_MAX;
        2: thr = '1;
        default: thr = DIST_BITS'({$urandom, $urandom} >> $urandom_range(30, 63));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      set_config(DIM_CFG_BITS'(d), thr);
      repeat ($urandom_range(1, 4)) begin
        n = ($urandom_range(0, 15) < 14) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        partial = ($urandom_range(0, 3) == 0) ? $urandom_range(0, dim_eff - 1) : 0;
        case ($urandom_range(0, 4))
          0: span = 0;
          1: span = 15;
          2: span = 255;
          3: span = 4095;
          default: span = 65535;
        endcase
        send_set(n, partial, span);
      end
      finish_phase();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/mpd_pkg.sv
sv/mpd_dist_unit.sv
sv/min_pair_distance_check.sv
sim/tb_min_pair_distance_check.sv
